// File: rtl/cpu_exu_pkg.sv
// Package with operation codes, flag positions and item types of the execute unit.
`default_nettype none
package cpu_exu_pkg;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,  OP_BCS = 6'd4,
      OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,  OP_BNE = 6'd8,  OP_BPL = 6'd9,
      OP_BRA = 6'd10, OP_BVC = 6'd11, OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14,
      OP_CLI = 6'd15, OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
      OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23, OP_INC = 6'd24,
      OP_INX = 6'd25, OP_INY = 6'd26, OP_LDA = 6'd27, OP_LDX = 6'd28, OP_LDY = 6'd29,
      OP_LSR = 6'd30, OP_NOP = 6'd31, OP_ORA = 6'd32, OP_PHA = 6'd33, OP_PHP = 6'd34,
      OP_PHX = 6'd35, OP_PHY = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_PLX = 6'd39,
      OP_PLY = 6'd40, OP_ROL = 6'd41, OP_ROR = 6'd42, OP_SBC = 6'd43, OP_SEC = 6'd44,
      OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47, OP_STX = 6'd48, OP_STY = 6'd49,
      OP_STZ = 6'd50, OP_TAX = 6'd51, OP_TAY = 6'd52, OP_TRB = 6'd53, OP_TSB = 6'd54,
      OP_TSX = 6'd55, OP_TXA = 6'd56, OP_TXS = 6'd57, OP_TYA = 6'd58
   } op_type;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] SP_RESET = 8'hFD;

   typedef struct packed {
      logic [5:0] mode;
      logic [7:0] operand;
      logic       to_accumulator;
   } req_type;

   typedef struct packed {
      logic [7:0] store_data;
      logic       store_valid;
      logic       branch_taken;
      logic [7:0] stack_before;
      logic [7:0] status_out;
      logic [7:0] acc_out;
      logic [7:0] xreg_out;
      logic [7:0] yreg_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] xr;
      logic [7:0] yr;
      logic [7:0] sp;
      logic [7:0] st;
   } regs_type;

endpackage
`default_nettype wire

// File: rtl/cpu_exu_alu.sv
// Combinational execution of one operation on the current register file.
`default_nettype none
module cpu_exu_alu (
   input  var cpu_exu_pkg::req_type  req,
   input  var cpu_exu_pkg::regs_type regs,
   output cpu_exu_pkg::regs_type     regs_next,
   output cpu_exu_pkg::rsp_type      rsp
);
   import cpu_exu_pkg::*;

   logic [7:0] src;
   logic [7:0] addend;
   logic [8:0] sum;
   logic [7:0] r;
   logic [8:0] diff;
   logic [7:0] cmp_reg;
   logic       set_nz;
   logic [7:0] nz_val;

   assign src    = req.to_accumulator ? regs.acc : req.operand;
   assign addend = (req.mode == OP_SBC) ? ~req.operand : req.operand;
   assign sum    = {1'b0, regs.acc} + {1'b0, addend} + {8'd0, regs.st[FLAG_C]};
   assign cmp_reg = (req.mode == OP_CPX) ? regs.xr : (req.mode == OP_CPY) ? regs.yr : regs.acc;
   assign diff   = {1'b0, cmp_reg} - {1'b0, req.operand};

   always_comb begin
      regs_next = regs;
      rsp = '0;
      rsp.stack_before = regs.sp;
      set_nz = 1'b0;
      nz_val = 8'd0;
      r = 8'd0;
      case (req.mode)
         OP_ADC, OP_SBC: begin
            regs_next.acc = sum[7:0];
            regs_next.st[FLAG_C] = sum[8];
            regs_next.st[FLAG_V] = ~(regs.acc[7] ^ addend[7]) & (regs.acc[7] ^ sum[7]);
            set_nz = 1'b1; nz_val = sum[7:0];
         end
         OP_AND: begin
            regs_next.acc = regs.acc & req.operand; set_nz = 1'b1; nz_val = regs_next.acc;
         end
         OP_EOR: begin
            regs_next.acc = regs.acc ^ req.operand; set_nz = 1'b1; nz_val = regs_next.acc;
         end
         OP_ORA: begin
            regs_next.acc = regs.acc | req.operand; set_nz = 1'b1; nz_val = regs_next.acc;
         end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
            case (req.mode)
               OP_ASL: begin
                  r = {src[6:0], 1'b0}; regs_next.st[FLAG_C] = src[7];
               end
               OP_LSR: begin
                  r = {1'b0, src[7:1]}; regs_next.st[FLAG_C] = src[0];
               end
               OP_ROL: begin
                  r = {src[6:0], regs.st[FLAG_C]}; regs_next.st[FLAG_C] = src[7];
               end
               OP_ROR: begin
                  r = {regs.st[FLAG_C], src[7:1]}; regs_next.st[FLAG_C] = src[0];
               end
               OP_INC: r = src + 8'd1;
               default: r = src - 8'd1;
            endcase
            set_nz = 1'b1; nz_val = r;
            if (req.to_accumulator) begin
               regs_next.acc = r;
            end else begin
               rsp.store_data = r; rsp.store_valid = 1'b1;
            end
         end
         OP_BCC: rsp.branch_taken = ~regs.st[FLAG_C];
         OP_BCS: rsp.branch_taken = regs.st[FLAG_C];
         OP_BEQ: rsp.branch_taken = regs.st[FLAG_Z];
         OP_BNE: rsp.branch_taken = ~regs.st[FLAG_Z];
         OP_BMI: rsp.branch_taken = regs.st[FLAG_N];
         OP_BPL: rsp.branch_taken = ~regs.st[FLAG_N];
         OP_BVS: rsp.branch_taken = regs.st[FLAG_V];
         OP_BVC: rsp.branch_taken = ~regs.st[FLAG_V];
         OP_BRA: rsp.branch_taken = 1'b1;
         OP_BIT: begin
            regs_next.st[FLAG_Z] = (regs.acc & req.operand) == 8'd0;
            regs_next.st[FLAG_N] = req.operand[7];
            regs_next.st[FLAG_V] = req.operand[6];
         end
         OP_CLC: regs_next.st[FLAG_C] = 1'b0;
         OP_CLD: regs_next.st[FLAG_D] = 1'b0;
         OP_CLI: regs_next.st[FLAG_I] = 1'b0;
         OP_CLV: regs_next.st[FLAG_V] = 1'b0;
         OP_SEC: regs_next.st[FLAG_C] = 1'b1;
         OP_SED: regs_next.st[FLAG_D] = 1'b1;
         OP_SEI: regs_next.st[FLAG_I] = 1'b1;
         OP_CMP, OP_CPX, OP_CPY: begin
            regs_next.st[FLAG_C] = ~diff[8]; set_nz = 1'b1; nz_val = diff[7:0];
         end
         OP_DEX: begin
            regs_next.xr = regs.xr - 8'd1; set_nz = 1'b1; nz_val = regs_next.xr;
         end
         OP_DEY: begin
            regs_next.yr = regs.yr - 8'd1; set_nz = 1'b1; nz_val = regs_next.yr;
         end
         OP_INX: begin
            regs_next.xr = regs.xr + 8'd1; set_nz = 1'b1; nz_val = regs_next.xr;
         end
         OP_INY: begin
            regs_next.yr = regs.yr + 8'd1; set_nz = 1'b1; nz_val = regs_next.yr;
         end
         OP_LDA: begin
            regs_next.acc = req.operand; set_nz = 1'b1; nz_val = req.operand;
         end
         OP_LDX: begin
            regs_next.xr = req.operand; set_nz = 1'b1; nz_val = req.operand;
         end
         OP_LDY: begin
            regs_next.yr = req.operand; set_nz = 1'b1; nz_val = req.operand;
         end
         OP_PHA, OP_PHP, OP_PHX, OP_PHY: begin
            case (req.mode)
               OP_PHA:  rsp.store_data = regs.acc;
               OP_PHP:  rsp.store_data = regs.st;
               OP_PHX:  rsp.store_data = regs.xr;
               default: rsp.store_data = regs.yr;
            endcase
            rsp.store_valid = 1'b1;
            regs_next.sp = regs.sp - 8'd1;
         end
         OP_PLA: begin
            regs_next.sp = regs.sp + 8'd1; regs_next.acc = req.operand;
            set_nz = 1'b1; nz_val = req.operand;
         end
         OP_PLX: begin
            regs_next.sp = regs.sp + 8'd1; regs_next.xr = req.operand;
            set_nz = 1'b1; nz_val = req.operand;
         end
         OP_PLY: begin
            regs_next.sp = regs.sp + 8'd1; regs_next.yr = req.operand;
            set_nz = 1'b1; nz_val = req.operand;
         end
         OP_PLP: begin
            regs_next.sp = regs.sp + 8'd1; regs_next.st = req.operand;
         end
         OP_STA: begin
            rsp.store_data = regs.acc; rsp.store_valid = 1'b1;
         end
         OP_STX: begin
            rsp.store_data = regs.xr; rsp.store_valid = 1'b1;
         end
         OP_STY: begin
            rsp.store_data = regs.yr; rsp.store_valid = 1'b1;
         end
         OP_STZ: rsp.store_valid = 1'b1;
         OP_TRB: begin
            regs_next.st[FLAG_Z] = (regs.acc & req.operand) == 8'd0;
            rsp.store_data = req.operand & ~regs.acc; rsp.store_valid = 1'b1;
         end
         OP_TSB: begin
            regs_next.st[FLAG_Z] = (regs.acc & req.operand) == 8'd0;
            rsp.store_data = req.operand | regs.acc; rsp.store_valid = 1'b1;
         end
         OP_TAX: begin
            regs_next.xr = regs.acc; set_nz = 1'b1; nz_val = regs.acc;
         end
         OP_TAY: begin
            regs_next.yr = regs.acc; set_nz = 1'b1; nz_val = regs.acc;
         end
         OP_TSX: begin
            regs_next.xr = regs.sp; set_nz = 1'b1; nz_val = regs.sp;
         end
         OP_TXA: begin
            regs_next.acc = regs.xr; set_nz = 1'b1; nz_val = regs.xr;
         end
         OP_TYA: begin
            regs_next.acc = regs.yr; set_nz = 1'b1; nz_val = regs.yr;
         end
         OP_TXS: regs_next.sp = regs.xr;
         default: ;
      endcase
      if (set_nz) begin
         regs_next.st[FLAG_Z] = nz_val == 8'd0;
         regs_next.st[FLAG_N] = nz_val[7];
      end
      rsp.status_out = regs_next.st;
      rsp.acc_out    = regs_next.acc;
      rsp.xreg_out   = regs_next.xr;
      rsp.yreg_out   = regs_next.yr;
   end

endmodule
`default_nettype wire

// File: rtl/eight_bit_cpu_execute_unit.sv
// Top level of the execute unit: input register, register file and result register.
//
// The unit executes one operation per item on its own A, X, Y, stack pointer and
// status registers. Items enter on the req_ channel (mode, operand, to_accumulator)
// and results leave on the rsp_ channel as one rsp_type item per input item.
// An accepted item is held in an input register; once the output register is free
// or being emptied, the operation is evaluated by the combinational ALU, the register
// file is updated and the result is written into the output register. rsp_valid rises
// when the result is registered there, and one item per cycle is sustained while the
// receiver takes results.
// The register file updates when an item moves from the input register to the
// output register, so items see each other's effects in order.
// When the receiver stalls, the result stays in the output register, the item in
// the input register waits, and req_ready drops while both are full and rsp_ready
// is low.
// Reset empties both registers and sets A, X, Y and status to zero and the stack
// pointer to 0xFD.
`default_nettype none
module eight_bit_cpu_execute_unit (
   input  var logic                 clock,
   input  var logic                 reset,
   input  var logic                 req_valid,
   output logic                     req_ready,
   input  var cpu_exu_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  var logic                 rsp_ready,
   output cpu_exu_pkg::rsp_type     rsp_data
);
   import cpu_exu_pkg::*;

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff;
   regs_type regs_ff, regs_next;
   rsp_type  alu_rsp;
   logic     advance;

   cpu_exu_alu u_alu (
      .req       (in_data_ff),
      .regs      (regs_ff),
      .regs_next (regs_next),
      .rsp       (alu_rsp)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         regs_ff      <= '{acc: 8'd0, xr: 8'd0, yr: 8'd0, sp: SP_RESET, st: 8'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            regs_ff <= regs_next;
         end
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= alu_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
`default_nettype wire

// File: rtl/cpu_exu_checker.sv
// Port checker for the execute unit, bound to its top level.
`default_nettype none
module cpu_exu_checker (
   input var logic                 clock,
   input var logic                 reset,
   input var logic                 req_ready,
   input var logic                 rsp_valid,
   input var logic                 rsp_ready,
   input var cpu_exu_pkg::rsp_type rsp_data
);
   import cpu_exu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Result item changed while stalled.");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("Input refused while output is empty.");

   a_store_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.store_valid |-> rsp_data.store_data == 8'd0)
      else $error("Store data without store valid.");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result item right after reset.");

endmodule

bind eight_bit_cpu_execute_unit cpu_exu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

// File: tb/eight_bit_cpu_execute_unit_tb.sv
// Testbench of the execute unit: directed table and random operations checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module eight_bit_cpu_execute_unit_tb;
   import cpu_exu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1900;

   typedef struct {
      req_type    req;
      logic       has_fixed;
      rsp_type    fixed;
   } row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p;
   rsp_type    pending_results[$];
   row_type    directed_rows[$];
   int         error_count = 0;
   int         result_count = 0;
   int         idle_cycles = 0;
   int         rsp_wait = 0;
   bit         stimulus_done = 1'b0;

   eight_bit_cpu_execute_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] set_nz(input logic [7:0] v);
      cpu_p[FLAG_Z] = (v == 8'h00);
      cpu_p[FLAG_N] = v[7];
      return v;
   endfunction

   function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b} + {8'h00, cpu_p[FLAG_C]};
      cpu_p[FLAG_C] = sum[8];
      cpu_p[FLAG_V] = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
      return set_nz(sum[7:0]);
   endfunction

   function automatic void compare_reg(input logic [7:0] r, input logic [7:0] v);
      cpu_p[FLAG_C] = (r >= v);
      void'(set_nz(r - v));
   endfunction

   function automatic rsp_type execute_op(input req_type q);
      rsp_type    res;
      logic [7:0] v, src, r;
      logic       cin;
      res = '0;
      res.stack_before = cpu_sp;
      v = q.operand;
      cin = cpu_p[FLAG_C];
      src = q.to_accumulator ? cpu_a : v;
      case (q.mode)
         OP_ADC: cpu_a = add_carry(cpu_a, v);
         OP_SBC: cpu_a = add_carry(cpu_a, ~v);
         OP_AND: cpu_a = set_nz(cpu_a & v);
         OP_EOR: cpu_a = set_nz(cpu_a ^ v);
         OP_ORA: cpu_a = set_nz(cpu_a | v);
         OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
            case (q.mode)
               OP_ASL: begin cpu_p[FLAG_C] = src[7]; r = {src[6:0], 1'b0}; end
               OP_LSR: begin cpu_p[FLAG_C] = src[0]; r = {1'b0, src[7:1]}; end
               OP_ROL: begin cpu_p[FLAG_C] = src[7]; r = {src[6:0], cin}; end
               OP_ROR: begin cpu_p[FLAG_C] = src[0]; r = {cin, src[7:1]}; end
               OP_INC: r = src + 8'd1;
               default: r = src - 8'd1;
            endcase
            void'(set_nz(r));
            if (q.to_accumulator) begin
               cpu_a = r;
            end else begin
               res.store_data = r;
               res.store_valid = 1'b1;
            end
         end
         OP_BCC: res.branch_taken = ~cpu_p[FLAG_C];
         OP_BCS: res.branch_taken = cpu_p[FLAG_C];
         OP_BEQ: res.branch_taken = cpu_p[FLAG_Z];
         OP_BNE: res.branch_taken = ~cpu_p[FLAG_Z];
         OP_BMI: res.branch_taken = cpu_p[FLAG_N];
         OP_BPL: res.branch_taken = ~cpu_p[FLAG_N];
         OP_BVS: res.branch_taken = cpu_p[FLAG_V];
         OP_BVC: res.branch_taken = ~cpu_p[FLAG_V];
         OP_BRA: res.branch_taken = 1'b1;
         OP_BIT: begin
            cpu_p[FLAG_Z] = ((cpu_a & v) == 8'h00);
            cpu_p[FLAG_N] = v[7];
            cpu_p[FLAG_V] = v[6];
         end
         OP_CLC: cpu_p[FLAG_C] = 1'b0;
         OP_CLD: cpu_p[FLAG_D] = 1'b0;
         OP_CLI: cpu_p[FLAG_I] = 1'b0;
         OP_CLV: cpu_p[FLAG_V] = 1'b0;
         OP_SEC: cpu_p[FLAG_C] = 1'b1;
         OP_SED: cpu_p[FLAG_D] = 1'b1;
         OP_SEI: cpu_p[FLAG_I] = 1'b1;
         OP_CMP: compare_reg(cpu_a, v);
         OP_CPX: compare_reg(cpu_x, v);
         OP_CPY: compare_reg(cpu_y, v);
         OP_DEX: cpu_x = set_nz(cpu_x - 8'd1);
         OP_DEY: cpu_y = set_nz(cpu_y - 8'd1);
         OP_INX: cpu_x = set_nz(cpu_x + 8'd1);
         OP_INY: cpu_y = set_nz(cpu_y + 8'd1);
         OP_LDA: cpu_a = set_nz(v);
         OP_LDX: cpu_x = set_nz(v);
         OP_LDY: cpu_y = set_nz(v);
         OP_PHA, OP_PHP, OP_PHX, OP_PHY: begin
            case (q.mode)
               OP_PHA: res.store_data = cpu_a;
               OP_PHP: res.store_data = cpu_p;
               OP_PHX: res.store_data = cpu_x;
               default: res.store_data = cpu_y;
            endcase
            res.store_valid = 1'b1;
            cpu_sp = cpu_sp - 8'd1;
         end
         OP_PLA: begin cpu_sp = cpu_sp + 8'd1; cpu_a = set_nz(v); end
         OP_PLX: begin cpu_sp = cpu_sp + 8'd1; cpu_x = set_nz(v); end
         OP_PLY: begin cpu_sp = cpu_sp + 8'd1; cpu_y = set_nz(v); end
         OP_PLP: begin cpu_sp = cpu_sp + 8'd1; cpu_p = v; end
         OP_STA: begin res.store_data = cpu_a; res.store_valid = 1'b1; end
         OP_STX: begin res.store_data = cpu_x; res.store_valid = 1'b1; end
         OP_STY: begin res.store_data = cpu_y; res.store_valid = 1'b1; end
         OP_STZ: begin res.store_data = 8'h00; res.store_valid = 1'b1; end
         OP_TRB: begin
            cpu_p[FLAG_Z] = ((cpu_a & v) == 8'h00);
            res.store_data = v & ~cpu_a;
            res.store_valid = 1'b1;
         end
         OP_TSB: begin
            cpu_p[FLAG_Z] = ((cpu_a & v) == 8'h00);
            res.store_data = v | cpu_a;
            res.store_valid = 1'b1;
         end
         OP_TAX: cpu_x = set_nz(cpu_a);
         OP_TAY: cpu_y = set_nz(cpu_a);
         OP_TSX: cpu_x = set_nz(cpu_sp);
         OP_TXA: cpu_a = set_nz(cpu_x);
         OP_TYA: cpu_a = set_nz(cpu_y);
         OP_TXS: cpu_sp = cpu_x;
         default: ;
      endcase
      res.status_out = cpu_p;
      res.acc_out = cpu_a;
      res.xreg_out = cpu_x;
      res.yreg_out = cpu_y;
      return res;
   endfunction

   function automatic rsp_type fixed_rsp(input logic [7:0] sd, input logic sv, input logic bt,
                                         input logic [7:0] sp, input logic [7:0] st,
                                         input logic [7:0] a, input logic [7:0] x,
                                         input logic [7:0] y);
      rsp_type r;
      r = '{sd, sv, bt, sp, st, a, x, y};
      return r;
   endfunction

   task automatic add_row(input op_type m, input logic [7:0] v, input logic ta,
                          input logic has_fixed, input rsp_type fixed);
      row_type row;
      row.req = '{m, v, ta};
      row.has_fixed = has_fixed;
      row.fixed = fixed;
      directed_rows.push_back(row);
   endtask

   task automatic send_item(input req_type q, input logic has_fixed, input rsp_type fixed);
      rsp_type predicted;
      int      gap;
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      predicted = execute_op(q);
      if (has_fixed && predicted != fixed) begin
         $display("%0t predictor disagrees with table: expected %h actual %h",
                  $time, fixed, predicted);
         error_count++;
      end
      pending_results.push_back(has_fixed ? fixed : predicted);
   endtask

   function automatic req_type random_item();
      req_type q;
      int      pick;
      pick = $urandom_range(0, 99);
      q.mode = (pick < 3) ? 6'($urandom_range(59, 63)) : 6'($urandom_range(0, 58));
      pick = $urandom_range(0, 9);
      q.operand = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : (pick == 2) ? 8'h80 :
                  (pick == 3) ? 8'h7F : 8'($urandom);
      q.to_accumulator = 1'($urandom_range(0, 1));
      return q;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result: expected none actual %h", $time, rsp_data);
               error_count++;
            end else begin
               rsp_type e;
               e = pending_results.pop_front();
               if (rsp_data.store_data !== e.store_data ||
                   rsp_data.store_valid !== e.store_valid ||
                   rsp_data.branch_taken !== e.branch_taken ||
                   rsp_data.stack_before !== e.stack_before ||
                   rsp_data.status_out !== e.status_out ||
                   rsp_data.acc_out !== e.acc_out ||
                   rsp_data.xreg_out !== e.xreg_out ||
                   rsp_data.yreg_out !== e.yreg_out) begin
                  $display("%0t result mismatch: expected %h actual %h", $time, e, rsp_data);
                  error_count++;
               end
            end
            rsp_wait = $urandom_range(0, 14);
            if (rsp_wait > 0) begin
               rsp_ready <= 1'b0;
               rsp_wait--;
            end
         end else if (!rsp_ready) begin
            if (rsp_wait == 0) rsp_ready <= 1'b1;
            else rsp_wait--;
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      cpu_a = 8'h00; cpu_x = 8'h00; cpu_y = 8'h00; cpu_sp = SP_RESET; cpu_p = 8'h00;
      add_row(OP_NOP, 8'hFF, 1'b1, 1'b1,
              fixed_rsp(8'h00, 1'b0, 1'b0, 8'hFD, 8'h00, 8'h00, 8'h00, 8'h00));
      add_row(OP_BRA, 8'h00, 1'b0, 1'b1,
              fixed_rsp(8'h00, 1'b0, 1'b1, 8'hFD, 8'h00, 8'h00, 8'h00, 8'h00));
      add_row(OP_LDA, 8'h00, 1'b0, 1'b1,
              fixed_rsp(8'h00, 1'b0, 1'b0, 8'hFD, 8'h02, 8'h00, 8'h00, 8'h00));
      add_row(OP_LDA, 8'hFF, 1'b0, 1'b1,
              fixed_rsp(8'h00, 1'b0, 1'b0, 8'hFD, 8'h80, 8'hFF, 8'h00, 8'h00));
      add_row(OP_PHA, 8'h00, 1'b0, 1'b1,
              fixed_rsp(8'hFF, 1'b1, 1'b0, 8'hFD, 8'h80, 8'hFF, 8'h00, 8'h00));
      add_row(OP_ADC, 8'h01, 1'b0, 1'b1,
              fixed_rsp(8'h00, 1'b0, 1'b0, 8'hFC, 8'h03, 8'h00, 8'h00, 8'h00));
      add_row(OP_LDA, 8'h7F, 1'b0, 1'b0, '0);
      add_row(OP_ADC, 8'h01, 1'b1, 1'b0, '0);
      add_row(OP_SBC, 8'hFF, 1'b0, 1'b0, '0);
      add_row(OP_CMP, 8'h80, 1'b0, 1'b0, '0);
      add_row(OP_ROL, 8'h80, 1'b0, 1'b0, '0);
      add_row(OP_ROR, 8'h01, 1'b1, 1'b0, '0);
      add_row(OP_BIT, 8'hC0, 1'b0, 1'b0, '0);
      add_row(OP_TSB, 8'h0F, 1'b0, 1'b0, '0);
      add_row(OP_TRB, 8'hF0, 1'b0, 1'b0, '0);
      add_row(OP_LDX, 8'h00, 1'b0, 1'b0, '0);
      add_row(OP_TXS, 8'h00, 1'b0, 1'b0, '0);
      add_row(OP_PLP, 8'hFF, 1'b0, 1'b0, '0);
      add_row(OP_PHP, 8'h00, 1'b0, 1'b0, '0);
      add_row(OP_DEC, 8'h00, 1'b0, 1'b0, '0);
      add_row(OP_INC, 8'hFF, 1'b1, 1'b0, '0);
      add_row(OP_TSX, 8'h00, 1'b0, 1'b0, '0);
      add_row(OP_CPY, 8'h01, 1'b0, 1'b0, '0);
      add_row(op_type'(6'd63), 8'hAA, 1'b1, 1'b0, '0);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_item(directed_rows[i].req, directed_rows[i].has_fixed, directed_rows[i].fixed);
      for (int i = 0; i < RANDOM_ITEMS; i++) send_item(random_item(), 1'b0, '0);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Ran %0d directed and %0d random operations over all modes, %0d results checked.",
               directed_rows.size(), RANDOM_ITEMS, result_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
